[design/obfu_pkg.sv]
`default_nettype none

package obfu_pkg;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // magnitude word and normalized mantissa widths
  localparam int MAG_W     = 64;
  localparam int NORM_BITS = 30;

endpackage

`default_nettype wire

[design/obfu_norm.sv]
`default_nettype none

module obfu_norm #(
  parameter int             VW      = 63,
  parameter int             FRAC    = 16,
  parameter int             TW      = 8,
  parameter obfu_pkg::axis_e FB_AXIS = obfu_pkg::AXIS_X
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   vld_i,
  input  wire logic signed [VW-1:0]   v_i [3],
  input  wire logic        [TW-1:0]   tag_i,
  output logic                        vld_o,
  output logic signed [FRAC+1:0]      q_o [3],
  output logic                        fb_o,
  output logic        [TW-1:0]        tag_o
);
  import obfu_pkg::*;

  localparam int MW = MAG_W;
  localparam int NB = NORM_BITS;
  localparam int SW = 2 * NB + 2;
  localparam int RB = NB + 1;
  localparam int QB = FRAC + 1;
  localparam int NW = NB + 1 + FRAC;
  localparam int RW = NB + 2;
  localparam int OW = FRAC + 2;
  localparam logic signed [OW-1:0] ONE = OW'(1) << FRAC;

  typedef struct packed {
    logic [2:0][NB-1:0] mn;
    logic [2:0]         neg;
    logic               zero;
    logic [TW-1:0]      tag;
  } side_t;

  // magnitudes
  logic          a_v_q;
  logic [MW-1:0] a_m_q [3];
  logic [2:0]    a_neg_q;
  logic [TW-1:0] a_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= v_i[i][VW-1];
        a_m_q[i]   <= v_i[i][VW-1] ? -MW'(v_i[i]) : MW'(v_i[i]);
      end
      a_tag_q <= tag_i;
    end
  end

  // coarse normalize
  logic          b_v_q;
  logic [MW-1:0] b_m_q [3];
  logic [MW-1:0] b_or_q;
  logic [2:0]    b_neg_q;
  logic          b_zero_q;
  logic [TW-1:0] b_tag_q;
  logic [MW-1:0] b_m_d [3];
  logic [MW-1:0] b_or_d;

  always_comb begin
    b_or_d = a_m_q[0] | a_m_q[1] | a_m_q[2];
    for (int i = 0; i < 3; i++) b_m_d[i] = a_m_q[i];
    for (int k = 0; k < 3; k++) begin
      if ((b_or_d >> (MW - (32 >> k))) == '0) begin
        b_or_d = b_or_d << (32 >> k);
        for (int i = 0; i < 3; i++) b_m_d[i] = b_m_d[i] << (32 >> k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_m_q    <= b_m_d;
      b_or_q   <= b_or_d;
      b_neg_q  <= a_neg_q;
      b_zero_q <= (a_m_q[0] | a_m_q[1] | a_m_q[2]) == '0;
      b_tag_q  <= a_tag_q;
    end
  end

  // fine normalize
  logic          c_v_q;
  side_t         c_s_q;
  logic [MW-1:0] c_m_d [3];
  logic [MW-1:0] c_or_d;

  always_comb begin
    c_or_d = b_or_q;
    for (int i = 0; i < 3; i++) c_m_d[i] = b_m_q[i];
    for (int k = 0; k < 3; k++) begin
      if ((c_or_d >> (MW - (4 >> k))) == '0) begin
        c_or_d = c_or_d << (4 >> k);
        for (int i = 0; i < 3; i++) c_m_d[i] = c_m_d[i] << (4 >> k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) c_s_q.mn[i] <= c_m_d[i][MW-1 -: NB];
      c_s_q.neg  <= b_neg_q;
      c_s_q.zero <= b_zero_q;
      c_s_q.tag  <= b_tag_q;
    end
  end

  // squares
  logic            d_v_q;
  side_t           d_s_q;
  logic [2*NB-1:0] d_sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en_i) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) d_sq_q[i] <= c_s_q.mn[i] * c_s_q.mn[i];
      d_s_q <= c_s_q;
    end
  end

  // square root, one result bit per stage
  logic          sq_v_q [RB+1];
  side_t         sq_s_q [RB+1];
  logic [SW-1:0] sq_n_q [RB+1];
  logic [SW-1:0] sq_r_q [RB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_v_q[0] <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_n_q[0] <= SW'(d_sq_q[0]) + SW'(d_sq_q[1]) + SW'(d_sq_q[2]);
      sq_r_q[0] <= '0;
      sq_s_q[0] <= d_s_q;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam logic [SW-1:0] STEP = SW'(1) << (2 * (RB - 1 - j));
    logic [SW-1:0] t;
    logic          ge;

    assign t  = sq_r_q[j] + STEP;
    assign ge = sq_n_q[j] >= t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_n_q[j+1] <= ge ? sq_n_q[j] - t : sq_n_q[j];
        sq_r_q[j+1] <= ge ? (sq_r_q[j] >> 1) + STEP : sq_r_q[j] >> 1;
        sq_s_q[j+1] <= sq_s_q[j];
      end
    end
  end

  // rounded division, one quotient bit per stage
  logic          dv_v_q   [QB+1];
  side_t         dv_s_q   [QB+1];
  logic [RB-1:0] dv_r_q   [QB+1];
  logic [NW-1:0] dv_num_q [QB+1][3];
  logic [RW-1:0] dv_rem_q [QB+1][3];
  logic [QB-1:0] dv_quo_q [QB+1][3];
  logic [RB-1:0] root;
  logic [NW-1:0] num_d [3];

  assign root = sq_r_q[RB][RB-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NW'(sq_s_q[RB].mn[i]) << FRAC) + NW'(root >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= sq_v_q[RB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_num_q[0][i] <= num_d[i];
        dv_rem_q[0][i] <= RW'(num_d[i][NW-1:QB]);
        dv_quo_q[0][i] <= '0;
      end
      dv_r_q[0] <= root;
      dv_s_q[0] <= sq_s_q[RB];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] t  [3];
    logic [2:0]    ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dv_rem_q[j][i][RW-2:0], dv_num_q[j][i][QB-1-j]};
        ge[i] = t[i] >= RW'(dv_r_q[j]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= ge[i] ? t[i] - RW'(dv_r_q[j]) : t[i];
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][QB-2:0], ge[i]};
          dv_num_q[j+1][i] <= dv_num_q[j][i];
        end
        dv_r_q[j+1] <= dv_r_q[j];
        dv_s_q[j+1] <= dv_s_q[j];
      end
    end
  end

  // sign and fallback
  logic signed [OW-1:0] q_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_s_q[QB].zero) begin
        q_d[i] = (int'(FB_AXIS) == i) ? ONE : '0;
      end else if (dv_s_q[QB].neg[i]) begin
        q_d[i] = -$signed({1'b0, dv_quo_q[QB][i]});
      end else begin
        q_d[i] = $signed({1'b0, dv_quo_q[QB][i]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= dv_v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o   <= q_d;
      fb_o  <= dv_s_q[QB].zero;
      tag_o <= dv_s_q[QB].tag;
    end
  end

endmodule

`default_nettype wire

[design/orthonormal_basis_from_forward_up_top.sv]
`default_nettype none

// channel   dir  fields
// s_axis    in   tdata: fwd_x, fwd_y, fwd_z, up_in_x, up_in_y, up_in_z
// m_axis    out  tdata: up_out_x/y/z, right_out_x/y/z; tuser: up_fallback, right_fallback
//
// one request per cycle while no result waits on m_axis
// the two normalizers use bit-serial square root and division stages
// reset clears the valid bits only, no clearing pass
// the whole pipeline holds while a result waits on m_axis; bubbles stay in place during a stall

module orthonormal_basis_from_forward_up_top #(
  parameter int COMPONENT_WIDTH = 24,
  parameter int FRACTION_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // fwd_x, fwd_y, fwd_z, up_in_x, up_in_y, up_in_z
  input  wire logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // up_out_x, up_out_y, up_out_z, right_out_x, right_out_y, right_out_z
  output logic [((6*(FRACTION_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  // up_fallback, right_fallback
  output logic [1:0] m_axis_tuser
);
  import obfu_pkg::*;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int F     = FRACTION_BITS;
  localparam int OW    = F + 2;
  localparam int PW    = 2 * CW + 2;
  localparam int DW    = 63 - CW;
  localparam int LW    = DW / 2;
  localparam int HW    = DW - LW;
  localparam int UW    = 63;
  localparam int XW    = CW + F + 2;
  localparam int OUT_W = ((6 * OW + 7) / 8) * 8;
  localparam logic signed [63:0] DLIM = 64'sd1 <<< (61 - CW);
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

  logic en;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // input capture
  logic signed [CW-1:0] f1_q [3];
  logic signed [CW-1:0] a1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_q[i] <= s_axis_tdata[i*CW +: CW];
        a1_q[i] <= s_axis_tdata[(i+3)*CW +: CW];
      end
    end
  end

  // dot product terms
  logic signed [2*CW-1:0] p2_q [3];
  logic signed [CW-1:0]   f2_q [3];
  logic signed [CW-1:0]   a2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p2_q[i] <= f1_q[i] * a1_q[i];
      f2_q <= f1_q;
      a2_q <= a1_q;
    end
  end

  // round and clamp d
  logic signed [PW-1:0] psum;
  logic signed [PW-1:0] dr;
  logic signed [63:0]   d64;
  logic signed [63:0]   dcl;
  logic signed [DW-1:0] d3_q;
  logic signed [CW-1:0] f3_q [3];
  logic signed [CW-1:0] a3_q [3];

  assign psum = PW'(p2_q[0]) + PW'(p2_q[1]) + PW'(p2_q[2]);
  assign dr   = (psum + HALF) >>> F;
  assign d64  = 64'(dr);
  assign dcl  = (d64 > DLIM) ? DLIM : ((d64 < -DLIM) ? -DLIM : d64);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q <= dcl[DW-1:0];
      f3_q <= f2_q;
      a3_q <= a2_q;
    end
  end

  // f * d in two partial products
  logic signed [CW+LW:0]   plo4_q [3];
  logic signed [CW+HW-1:0] phi4_q [3];
  logic signed [CW-1:0]    f4_q   [3];
  logic signed [CW-1:0]    a4_q   [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        plo4_q[i] <= f3_q[i] * $signed({1'b0, d3_q[LW-1:0]});
        phi4_q[i] <= f3_q[i] * $signed(d3_q[DW-1:LW]);
      end
      f4_q <= f3_q;
      a4_q <= a3_q;
    end
  end

  // residual
  logic signed [UW-1:0] u5_q [3];
  logic signed [CW-1:0] f5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u5_q[i] <= (UW'(a4_q[i]) <<< F) - ((UW'(phi4_q[i]) <<< LW) + UW'(plo4_q[i]));
      end
      f5_q <= f4_q;
    end
  end

  logic                 n1_v;
  logic signed [OW-1:0] n1_q [3];
  logic                 n1_fb;
  logic [3*CW-1:0]      n1_tag;

  obfu_norm #(
    .VW      (UW),
    .FRAC    (F),
    .TW      (3 * CW),
    .FB_AXIS (AXIS_Y)
  ) u_norm_up (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v5_q),
    .v_i    (u5_q),
    .tag_i  ({f5_q[2], f5_q[1], f5_q[0]}),
    .vld_o  (n1_v),
    .q_o    (n1_q),
    .fb_o   (n1_fb),
    .tag_o  (n1_tag)
  );

  // cross products
  logic signed [CW-1:0]    fn [3];
  logic signed [OW+CW-1:0] cp6_q [6];
  logic signed [OW-1:0]    up6_q [3];
  logic                    ufb6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) fn[i] = n1_tag[i*CW +: CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v6_q <= n1_v;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp6_q[0] <= n1_q[1] * fn[2];
      cp6_q[1] <= n1_q[2] * fn[1];
      cp6_q[2] <= n1_q[2] * fn[0];
      cp6_q[3] <= n1_q[0] * fn[2];
      cp6_q[4] <= n1_q[0] * fn[1];
      cp6_q[5] <= n1_q[1] * fn[0];
      up6_q    <= n1_q;
      ufb6_q   <= n1_fb;
    end
  end

  logic signed [XW-1:0] c7_q  [3];
  logic signed [OW-1:0] up7_q [3];
  logic                 ufb7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q[0] <= XW'(cp6_q[0]) - XW'(cp6_q[1]);
      c7_q[1] <= XW'(cp6_q[2]) - XW'(cp6_q[3]);
      c7_q[2] <= XW'(cp6_q[4]) - XW'(cp6_q[5]);
      up7_q   <= up6_q;
      ufb7_q  <= ufb6_q;
    end
  end

  logic signed [OW-1:0] rt_q [3];
  logic                 rt_fb;
  logic [3*OW:0]        n2_tag;

  obfu_norm #(
    .VW      (XW),
    .FRAC    (F),
    .TW      (3 * OW + 1),
    .FB_AXIS (AXIS_X)
  ) u_norm_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v7_q),
    .v_i    (c7_q),
    .tag_i  ({ufb7_q, up7_q[2], up7_q[1], up7_q[0]}),
    .vld_o  (m_axis_tvalid),
    .q_o    (rt_q),
    .fb_o   (rt_fb),
    .tag_o  (n2_tag)
  );

  assign m_axis_tdata = OUT_W'({rt_q[2], rt_q[1], rt_q[0], n2_tag[3*OW-1:0]});
  assign m_axis_tuser = {rt_fb, n2_tag[3*OW]};

endmodule

`default_nettype wire
